// ----- src/bpgc_pkg.sv -----
// Shared types and constants for the button press gesture classifier.
// No dependencies; imported by bpgc_core, button_press_gesture_classifier and the bench.
`default_nettype none

package bpgc_pkg;

  localparam int unsigned KEY_W   = 10;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned GEST_W  = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 16;

  localparam logic [MS_W-1:0]   MS_MAX        = '1;
  localparam logic [CODE_W-1:0] CODE_NONE     = 4'd0;
  localparam logic [CODE_W-1:0] CODE_MAX      = 4'd9;

  localparam logic [KEY_W-1:0]  TARGET_KEY_RST = 10'd0;
  localparam logic [MS_W-1:0]   SHORT_LIM_RST  = 16'd500;
  localparam logic [MS_W-1:0]   DBL_WIN_RST    = 16'd300;

  // gesture codes on the result
  localparam logic [GEST_W-1:0] GEST_SHORT  = 2'd0;
  localparam logic [GEST_W-1:0] GEST_LONG   = 2'd1;
  localparam logic [GEST_W-1:0] GEST_DOUBLE = 2'd2;

  // input item kinds and key values
  localparam logic       ACT_TICK    = 1'b0;
  localparam logic [1:0] KEY_RELEASE = 2'd0;
  localparam logic [1:0] KEY_PRESS   = 2'd1;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_TARGET_KEY  = 3'd0,
    REG_SHORT_LIMIT = 3'd1,
    REG_DBL_WINDOW  = 3'd2,
    REG_SHORT_CODE  = 3'd3,
    REG_LONG_CODE   = 3'd4,
    REG_DBL_CODE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  target_key;
    logic [MS_W-1:0]   short_limit;
    logic [MS_W-1:0]   dbl_window;
    logic [CODE_W-1:0] short_code;
    logic [CODE_W-1:0] long_code;
    logic [CODE_W-1:0] dbl_code;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key_code;
    logic [1:0]       key_value;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [GEST_W-1:0] gesture;
    logic [CODE_W-1:0] code;
  } result_t;

  // codes above nine mean "none"
  function automatic logic [CODE_W-1:0] eff_code(input logic [CODE_W-1:0] c);
    return (c > CODE_MAX) ? CODE_NONE : c;
  endfunction

endpackage

`default_nettype wire

// ----- src/bpgc_core.sv -----
// Gesture state registers and the per-item update/classify logic.
// Depends on bpgc_pkg.
`default_nettype none

module bpgc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire bpgc_pkg::item_t  item,
  input  wire bpgc_pkg::cfg_t   cfg,
  output bpgc_pkg::result_t     res
);
  import bpgc_pkg::*;

  logic [MS_W-1:0] elapsed, elapsed_next;
  logic            pressed, pressed_next;
  logic [1:0]      short_cnt, short_cnt_next;
  logic            long_fired, long_fired_next;
  logic            held, held_next;

  logic [MS_W-1:0]   elapsed_inc;
  logic [1:0]        short_cnt_inc;
  logic [CODE_W-1:0] sc, lc, dc;
  logic              hit;
  logic [GEST_W-1:0] gest;
  logic [CODE_W-1:0] code;

  assign sc = eff_code(cfg.short_code);
  assign lc = eff_code(cfg.long_code);
  assign dc = eff_code(cfg.dbl_code);

  assign elapsed_inc   = (elapsed != MS_MAX) ? elapsed + 1'b1 : elapsed;
  assign short_cnt_inc = (short_cnt != 2'd3) ? short_cnt + 1'b1 : short_cnt;

  always_comb begin
    elapsed_next    = elapsed;
    pressed_next    = pressed;
    short_cnt_next  = short_cnt;
    long_fired_next = long_fired;
    held_next       = held;
    hit             = 1'b0;
    gest            = GEST_SHORT;
    code            = CODE_NONE;
    if (step) begin
      if (item.action == ACT_TICK) begin
        elapsed_next = elapsed_inc;
        // pending single short release timed out: plain short press
        priority if (dc != CODE_NONE && short_cnt == 2'd1 &&
                      elapsed_inc >= cfg.dbl_window) begin
          short_cnt_next  = 2'd0;
          pressed_next    = 1'b0;
          long_fired_next = 1'b0;
          hit  = 1'b1;
          gest = GEST_SHORT;
          code = sc;
        end else if (lc != CODE_NONE && pressed && held && !long_fired &&
                     elapsed_inc >= cfg.short_limit) begin
          short_cnt_next  = 2'd0;
          pressed_next    = 1'b0;
          long_fired_next = 1'b1;
          hit  = 1'b1;
          gest = GEST_LONG;
          code = lc;
        end else begin
          // nothing due on this tick
        end
      end else if (item.key_code == cfg.target_key) begin
        if (item.key_value == KEY_PRESS) begin
          elapsed_next    = '0;
          pressed_next    = 1'b1;
          long_fired_next = 1'b0;
          held_next       = 1'b1;
        end else if (item.key_value == KEY_RELEASE && held) begin
          held_next = 1'b0;
          if (!long_fired && elapsed < cfg.short_limit) begin
            priority if (dc == CODE_NONE) begin
              short_cnt_next  = 2'd0;
              pressed_next    = 1'b0;
              long_fired_next = 1'b0;
              hit  = 1'b1;
              gest = GEST_SHORT;
              code = sc;
            end else if (short_cnt_inc > 2'd1) begin
              short_cnt_next  = 2'd0;
              pressed_next    = 1'b0;
              long_fired_next = 1'b0;
              hit  = 1'b1;
              gest = GEST_DOUBLE;
              code = dc;
            end else begin
              short_cnt_next = short_cnt_inc;
            end
          end
        end
      end
    end
  end

  assign res.valid   = hit && (code != CODE_NONE);
  assign res.gesture = gest;
  assign res.code    = code;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      pressed    <= 1'b0;
      short_cnt  <= 2'd0;
      long_fired <= 1'b0;
      held       <= 1'b0;
    end else begin
      elapsed    <= elapsed_next;
      pressed    <= pressed_next;
      short_cnt  <= short_cnt_next;
      long_fired <= long_fired_next;
      held       <= held_next;
    end
  end

  // a second short release always resolves to a double, so the count stays at 0 or 1
  a_short_cnt_low: assert property (@(posedge clk) disable iff (rst)
    short_cnt == 2'd0 || short_cnt == 2'd1)
    else $error("short release count above one");

  // a long press consumes the pending press
  a_long_clears_press: assert property (@(posedge clk) disable iff (rst)
    !(long_fired && pressed))
    else $error("long fired with press still pending");

  // a press always restarts the tick count
  a_press_restarts: assert property (@(posedge clk) disable iff (rst)
    step && item.action != ACT_TICK && item.key_code == cfg.target_key &&
    item.key_value == KEY_PRESS |=> elapsed == '0 && held)
    else $error("press did not restart timing");

endmodule

`default_nettype wire

// ----- src/button_press_gesture_classifier.sv -----
// Requests pass through the input register and are evaluated there by bpgc_core;
//   a result, if any, is then registered in the output register.
// Throughput: one request per cycle while no held result stalls; the state update
//   in bpgc_core is the only loop. A held result stalls the full input register; item_ready follows result_ready.
// Reset (rst, synchronous): gesture state cleared, registers to their defaults.
// Top level of the button press gesture classifier; depends on bpgc_pkg, bpgc_core.
`default_nettype none

module button_press_gesture_classifier #(
  parameter logic [bpgc_pkg::KEY_W-1:0] TargetKeyRst = bpgc_pkg::TARGET_KEY_RST,
  parameter logic [bpgc_pkg::MS_W-1:0]  ShortLimRst  = bpgc_pkg::SHORT_LIM_RST,
  parameter logic [bpgc_pkg::MS_W-1:0]  DblWinRst    = bpgc_pkg::DBL_WIN_RST
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bpgc_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [bpgc_pkg::CDATA_W-1:0]   cfg_data,
  // input requests: ticks and key events
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire logic                           action,
  input  wire logic [bpgc_pkg::KEY_W-1:0]     key_code,
  input  wire logic [1:0]                     key_value,
  // recognized gestures
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic [bpgc_pkg::GEST_W-1:0]         gesture,
  output logic [bpgc_pkg::CODE_W-1:0]         action_code
);
  import bpgc_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers. The user must write only while idle, so
  // no hazard against the evaluate stage; the block does not enforce it; cfg is always ready.
  // ---------------------------------------------------------------
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_key  <= TargetKeyRst;
      cfg.short_limit <= ShortLimRst;
      cfg.dbl_window  <= DblWinRst;
      cfg.short_code  <= CODE_NONE;
      cfg.long_code   <= CODE_NONE;
      cfg.dbl_code    <= CODE_NONE;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_KEY:  cfg.target_key  <= cfg_data[KEY_W-1:0];
        REG_SHORT_LIMIT: cfg.short_limit <= cfg_data[MS_W-1:0];
        REG_DBL_WINDOW:  cfg.dbl_window  <= cfg_data[MS_W-1:0];
        REG_SHORT_CODE:  cfg.short_code  <= cfg_data[CODE_W-1:0];
        REG_LONG_CODE:   cfg.long_code   <= cfg_data[CODE_W-1:0];
        REG_DBL_CODE:    cfg.dbl_code    <= cfg_data[CODE_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input register. Holds one request; it advances into the core
  // when the output register is free or being drained.
  // ---------------------------------------------------------------
  logic  stg_valid, stg_valid_next;
  item_t stg_item;
  logic  advance;
  logic  item_acc;

  assign advance    = stg_valid && (!result_valid || result_ready);
  assign item_ready = !stg_valid || advance;
  assign item_acc   = item_valid && item_ready;

  always_comb begin
    stg_valid_next = stg_valid;
    if (item_acc)     stg_valid_next = 1'b1;
    else if (advance) stg_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) stg_valid <= 1'b0;
    else     stg_valid <= stg_valid_next;
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item_acc) begin
      stg_item.action    <= action;
      stg_item.key_code  <= key_code;
      stg_item.key_value <= key_value;
    end
  end

  // ---------------------------------------------------------------
  // Classifier: state update and gesture decision for one request.
  // ---------------------------------------------------------------
  result_t res;

  bpgc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (stg_item),
    .cfg  (cfg),
    .res  (res)
  );

  // ---------------------------------------------------------------
  // Output register. Loaded only when the evaluated request yields a
  // gesture with a nonzero action code.
  // ---------------------------------------------------------------
  logic result_valid_next;

  always_comb begin
    result_valid_next = result_valid;
    if (advance && res.valid) result_valid_next = 1'b1;
    else if (result_ready)    result_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= result_valid_next;
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      gesture     <= res.gesture;
      action_code <= res.code;
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> action_code != CODE_NONE && action_code <= CODE_MAX)
    else $error("result with bad action code");

  a_gest_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> gesture == GEST_SHORT || gesture == GEST_LONG ||
                     gesture == GEST_DOUBLE)
    else $error("result with bad gesture");

  // a stalled request must stay put in the input register
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid && result_valid && !result_ready |=> stg_valid && $stable(stg_item))
    else $error("input register lost a stalled request");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !stg_valid |-> item_ready)
    else $error("empty input register refused a request");

endmodule

`default_nettype wire

// ----- sim/button_press_gesture_classifier_tb.sv -----
// Self-checking bench for button_press_gesture_classifier: ticks and key events go in,
// gestures come out and are checked against an in-bench model of the classifier.
// Depends on bpgc_pkg and the classifier RTL; reads no files.
module button_press_gesture_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpgc_pkg::*;

  // bench knobs
  localparam int unsigned STALL_MAX      = 15;    // longest gap / stall per request
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned SETTLE         = 4;     // covers the two-stage pipeline (input and output registers)
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned REPORT_MAX     = 40;

  // codes the package leaves out
  localparam logic             ACT_KEY      = 1'b1;
  localparam logic [1:0]       KEY_REPEAT   = 2'd2;
  localparam logic [1:0]       KEY_BOGUS    = 2'd3;
  localparam logic [CIDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CIDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [GEST_W-1:0] gest;
    logic [CODE_W-1:0] code;
  } gesture_rec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index = '0;
  logic [CDATA_W-1:0]   cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic                 action = ACT_TICK;
  logic [KEY_W-1:0]     key_code = '0;
  logic [1:0]           key_value = KEY_RELEASE;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [GEST_W-1:0]    gesture;
  logic [CODE_W-1:0]    action_code;

  item_t        key_events_q[$];       // requests not yet presented
  gesture_rec_t expected_gestures[$];  // predicted gestures, oldest first

  int unsigned err_count   = 0;
  int unsigned issued      = 0;
  int unsigned send_gap    = 0;
  int unsigned recv_hold   = 0;
  int unsigned idle_cycles = 0;
  bit          in_calm     = 1'b0;  // no gaps on the request side this phase
  bit          out_calm    = 1'b0;  // no stalls on the result side this phase

  // model copy of registers and gesture state
  cfg_t            live_cfg;
  logic [MS_W-1:0] m_elapsed;
  logic            m_pending;
  logic [1:0]      m_shorts;
  logic            m_long_done;
  logic            m_held;

  button_press_gesture_classifier dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .action      (action),
    .key_code    (key_code),
    .key_value   (key_value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .gesture     (gesture),
    .action_code (action_code)
  );

  always #5ns clk = ~clk;

  function automatic int unsigned pause_len(input bit calm);
    return calm ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Gesture model
  // ---------------------------------------------------------------------------
  // a gesture with a zero (or out of range) code moves the state but shows nothing
  task automatic post_gesture(input logic [GEST_W-1:0] gest, input logic [CODE_W-1:0] code);
    if (code != CODE_NONE) expected_gestures.push_back('{gest, code});
  endtask

  task automatic clear_gesture_state();
    m_shorts    = 2'd0;
    m_pending   = 1'b0;
    m_long_done = 1'b0;
  endtask

  task automatic predict_gesture(input item_t req);
    logic [CODE_W-1:0] sc, lc, dc;
    // codes above nine count as none
    sc = (live_cfg.short_code > CODE_MAX) ? CODE_NONE : live_cfg.short_code;
    lc = (live_cfg.long_code > CODE_MAX) ? CODE_NONE : live_cfg.long_code;
    dc = (live_cfg.dbl_code > CODE_MAX) ? CODE_NONE : live_cfg.dbl_code;

    if (req.action == ACT_TICK) begin
      if (m_elapsed != MS_MAX) m_elapsed = m_elapsed + 1'b1;
      // a lone short release whose double window ran out becomes a short press
      if (dc != CODE_NONE && m_shorts == 2'd1 && m_elapsed >= live_cfg.dbl_window) begin
        clear_gesture_state();
        post_gesture(GEST_SHORT, sc);
      end else if (lc != CODE_NONE && m_pending && m_held && !m_long_done &&
                   m_elapsed >= live_cfg.short_limit) begin
        // long press needs the key still down; fires once per press
        m_shorts    = 2'd0;
        m_pending   = 1'b0;
        m_long_done = 1'b1;
        post_gesture(GEST_LONG, lc);
      end
    end else if (req.key_code == live_cfg.target_key) begin
      if (req.key_value == KEY_PRESS) begin
        // a press while held just restarts
        m_elapsed   = '0;
        m_pending   = 1'b1;
        m_long_done = 1'b0;
        m_held      = 1'b1;
      end else if (req.key_value == KEY_RELEASE && m_held) begin
        m_held = 1'b0;
        if (!m_long_done && m_elapsed < live_cfg.short_limit) begin
          if (dc == CODE_NONE) begin
            clear_gesture_state();
            post_gesture(GEST_SHORT, sc);
          end else begin
            if (m_shorts != 2'd3) m_shorts = m_shorts + 1'b1;
            if (m_shorts > 2'd1) begin
              clear_gesture_state();
              post_gesture(GEST_DOUBLE, dc);
            end
          end
        end
      end
      // autorepeat, value three and a release of an idle key fall through
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: one request per pop, with a drawn gap after each one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
      send_gap   <= 0;
    end else if (!item_valid || item_ready) begin
      if (send_gap != 0) begin
        item_valid <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (key_events_q.size() != 0) begin
        nxt = key_events_q.pop_front();
        item_valid <= 1'b1;
        action     <= nxt.action;
        key_code   <= nxt.key_code;
        key_value  <= nxt.key_value;
        send_gap   <= pause_len(in_calm);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result side: outside calm phases, stall after each accepted gesture and now and then at random
  always @(posedge clk) begin : pace_results
    int unsigned n;
    n = 0;
    if (rst) begin
      result_ready <= 1'b0;
      recv_hold    <= 0;
    end else if (recv_hold != 0) begin
      result_ready <= 1'b0;
      recv_hold    <= recv_hold - 1;
    end else begin
      if ((result_valid && result_ready) || $urandom_range(0, 7) == 0) n = pause_len(out_calm);
      result_ready <= (n == 0);
      recv_hold    <= (n == 0) ? 0 : n - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: register writes and requests feed the model, gestures are checked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    gesture_rec_t want;
    if (rst) begin
      live_cfg    = '{TARGET_KEY_RST, SHORT_LIM_RST, DBL_WIN_RST,
                      CODE_NONE, CODE_NONE, CODE_NONE};
      m_elapsed   = '0;
      m_pending   = 1'b0;
      m_shorts    = 2'd0;
      m_long_done = 1'b0;
      m_held      = 1'b0;
    end else begin
      // results first: a gesture seen now never belongs to this edge's request
      if (result_valid && result_ready) begin
        if (expected_gestures.size() == 0) begin
          report($sformatf("unexpected gesture %0d code %0d", gesture, action_code));
        end else begin
          want = expected_gestures.pop_front();
          if (gesture !== want.gest)
            report($sformatf("gesture %0d, want %0d", gesture, want.gest));
          if (action_code !== want.code)
            report($sformatf("action_code %0d, want %0d", action_code, want.code));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_KEY:  live_cfg.target_key  = cfg_data[KEY_W-1:0];
          REG_SHORT_LIMIT: live_cfg.short_limit = cfg_data[MS_W-1:0];
          REG_DBL_WINDOW:  live_cfg.dbl_window  = cfg_data[MS_W-1:0];
          REG_SHORT_CODE:  live_cfg.short_code  = cfg_data[CODE_W-1:0];
          REG_LONG_CODE:   live_cfg.long_code   = cfg_data[CODE_W-1:0];
          REG_DBL_CODE:    live_cfg.dbl_code    = cfg_data[CODE_W-1:0];
          default: ;  // spare indexes do nothing
        endcase
      end
      if (item_valid && item_ready) predict_gesture('{action, key_code, key_value});
    end
  end

  // Watchdog: any handshake restarts the count
  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic act, input logic [KEY_W-1:0] kc, input logic [1:0] kv);
    key_events_q.push_back('{act, kc, kv});
    issued++;
  endtask

  // ticks carry random key fields, which the block must ignore
  task automatic add_ticks(input int unsigned n);
    repeat (n) add_item(ACT_TICK, 10'($urandom_range(0, 1023)), 2'($urandom_range(0, 3)));
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // all six registers, junk in the unused upper data bits
  task automatic apply_setup(input cfg_t s);
    write_reg(REG_TARGET_KEY, {6'($urandom_range(0, 63)), s.target_key});
    write_reg(REG_SHORT_LIMIT, s.short_limit);
    write_reg(REG_DBL_WINDOW, s.dbl_window);
    write_reg(REG_SHORT_CODE, {12'($urandom_range(0, 4095)), s.short_code});
    write_reg(REG_LONG_CODE, {12'($urandom_range(0, 4095)), s.long_code});
    write_reg(REG_DBL_CODE, {12'($urandom_range(0, 4095)), s.dbl_code});
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                16'($urandom_range(0, 65535)));
  endtask

  // block is idle once nothing is queued, presented or expected
  task automatic drain();
    do @(negedge clk);
    while (key_events_q.size() != 0 || item_valid || expected_gestures.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [MS_W-1:0] pick_ms(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return MS_MAX;
    return 16'($urandom_range(1, hi));
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return CODE_NONE;
    if (r == 1) return 4'($urandom_range(10, 15));  // out of range, acts as none
    return 4'($urandom_range(1, 9));
  endfunction

  function automatic cfg_t pick_setup();
    cfg_t s;
    int unsigned r;
    r = $urandom_range(0, 7);
    s.target_key  = (r == 0) ? '0 : (r == 1) ? '1 : 10'($urandom_range(0, 1023));
    s.short_limit = pick_ms(12);
    s.dbl_window  = pick_ms(8);
    s.short_code  = pick_code();
    s.long_code   = pick_code();
    s.dbl_code    = pick_code();
    return s;
  endfunction

  // One gesture attempt on the target key, sized to the current limits, or noise.
  task automatic add_burst(input cfg_t s);
    int unsigned kind, hold_span, wait_span;
    logic [KEY_W-1:0] other;
    hold_span = (s.short_limit > 16) ? 18 : s.short_limit + 2;
    wait_span = (s.dbl_window > 16) ? 19 : s.dbl_window + 3;
    other     = s.target_key ^ 10'($urandom_range(1, 1023));
    kind      = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin  // single tap, hold around the short limit
        add_item(ACT_KEY, s.target_key, KEY_PRESS);
        add_ticks($urandom_range(0, hold_span));
        add_item(ACT_KEY, s.target_key, KEY_RELEASE);
        add_ticks($urandom_range(0, wait_span));
      end
      4, 5: begin  // two taps, gap around the double window
        repeat (2) begin
          add_item(ACT_KEY, s.target_key, KEY_PRESS);
          add_ticks($urandom_range(0, hold_span));
          add_item(ACT_KEY, s.target_key, KEY_RELEASE);
          add_ticks($urandom_range(0, wait_span));
        end
      end
      6, 7: begin  // hold past the limit, release maybe
        add_item(ACT_KEY, s.target_key, KEY_PRESS);
        add_ticks(((s.short_limit > 40) ? 40 : s.short_limit) + $urandom_range(0, 3));
        if ($urandom_range(0, 1)) add_item(ACT_KEY, s.target_key, KEY_RELEASE);
        add_ticks($urandom_range(0, 3));
      end
      8: begin  // raw noise
        repeat ($urandom_range(1, 4))
          add_item(1'($urandom_range(0, 1)),
                   $urandom_range(0, 1) ? s.target_key : 10'($urandom_range(0, 1023)),
                   2'($urandom_range(0, 3)));
      end
      default: begin  // broken sequence: foreign keys, repeats, double press, stray release
        add_item(ACT_KEY, s.target_key, KEY_PRESS);
        add_item(ACT_KEY, other, KEY_PRESS);
        add_item(ACT_KEY, s.target_key, KEY_REPEAT);
        add_ticks($urandom_range(0, hold_span));
        add_item(ACT_KEY, s.target_key, KEY_PRESS);
        add_item(ACT_KEY, s.target_key, KEY_BOGUS);
        add_item(ACT_KEY, other, KEY_RELEASE);
        add_item(ACT_KEY, s.target_key, KEY_RELEASE);
        add_item(ACT_KEY, s.target_key, KEY_RELEASE);
        add_ticks($urandom_range(0, wait_span));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    cfg_t        s;
    int unsigned budget;
    int unsigned phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, top key code: short at once (no double), long after two ticks,
    // release after long, stray release, foreign key, autorepeat, value three,
    // press while held.
    in_calm  = 1'b0;
    out_calm = 1'b0;
    s = '{10'h3FF, 16'd2, 16'd2, 4'd9, 4'd1, CODE_NONE};
    apply_setup(s);
    add_item(ACT_TICK, '1, KEY_BOGUS);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_ticks(3);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    add_item(ACT_KEY, '0, KEY_PRESS);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_item(ACT_KEY, s.target_key, KEY_REPEAT);
    add_item(ACT_KEY, s.target_key, KEY_BOGUS);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_ticks(1);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    drain();

    // Directed, key zero: double press, short code out of range after the
    // window, no long with long disabled, slow release ignored.
    s = '{10'd0, 16'd4, 16'd2, 4'd15, CODE_NONE, 4'd5};
    apply_setup(s);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_ticks(1);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    add_ticks(3);
    add_item(ACT_KEY, s.target_key, KEY_PRESS);
    add_ticks(4);
    add_item(ACT_KEY, s.target_key, KEY_RELEASE);
    drain();

    // Random phases; the first two pin the limits to their extremes.
    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      s = pick_setup();
      if (phase == 0) begin
        s.short_limit = '0;
        s.dbl_window  = MS_MAX;
      end else if (phase == 1) begin
        s.short_limit = MS_MAX;
        s.dbl_window  = '0;
      end
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      apply_setup(s);
      budget = issued + $urandom_range(60, 120);
      while (issued < budget) add_burst(s);
      drain();
      phase++;
    end

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bpgc_pkg.sv
src/bpgc_core.sv
src/button_press_gesture_classifier.sv
sim/button_press_gesture_classifier_tb.sv
